/* rtl/max_heap_priority_queue_assert.svh */
// Assertion macros for the max-heap priority queue.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// check a property on every clock edge outside reset
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define MHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mhpq_pkg.sv */
// Shared constants and codes for the max-heap priority queue.
// No dependencies.
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STATUS_W + VAL_W + VAL_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

/* rtl/mhpq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/max_heap_priority_queue.sv */
// A request on a full or empty heap goes straight to the finish state; an insert climbs
//   the heap level by level and a remove descends it level by level, and the next
//   request is taken while the result is shown.
// Each level is a heap RAM read, a compare and a write-back; a finished result waits in
//   the output register. Reset (rst_n, synchronous, active low) clears the fill count
//   and control state only. Depends on mhpq_pkg, mhpq_ram and the assertion header.
`include "max_heap_priority_queue_assert.svh"

module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value
  input  logic [0:0]             in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, removed_value, top_value, entry_count
);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_STEP, S_UP_CMP, S_DN_LAST, S_DN_STEP, S_DN_L, S_DN_R, S_FINISH
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         pos_r, pos_nxt;
  logic signed [VAL_W-1:0]  mv_r, mv_nxt;
  logic signed [VAL_W-1:0]  cv_r, cv_nxt;
  logic                     left_big_r, left_big_nxt;
  logic signed [VAL_W-1:0]  root_r, root_nxt;
  status_t                  status_r, status_nxt;
  logic signed [VAL_W-1:0]  removed_r, removed_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0]  out_removed_r, out_removed_nxt;
  logic signed [VAL_W-1:0]  out_top_r, out_top_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [VAL_W-1:0]         ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [VAL_W-1:0]         ram_rdata;
  logic signed [VAL_W-1:0]  rd_val;

  logic [CNT_W-1:0]         pos_m1;
  logic [CNT_W-1:0]         parent;
  logic [CNT_W-1:0]         parent_m1;
  logic [CNT_W:0]           left;
  logic [CNT_W:0]           left_m1;
  logic [CNT_W:0]           right;
  logic [CNT_W:0]           cnt_ext;
  logic [CNT_W-1:0]         cnt_m1;
  logic                     left_wins;

  mhpq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_val    = $signed(ram_rdata);
  assign pos_m1    = pos_r - CNT_W'(1);
  assign parent    = pos_r >> 1;
  assign parent_m1 = parent - CNT_W'(1);
  assign left      = {pos_r, 1'b0};
  assign left_m1   = left - (CNT_W + 1)'(1);
  assign right     = {pos_r, 1'b1};
  assign cnt_ext   = {1'b0, cnt_r};
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign left_wins = rd_val > mv_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_count_r, out_top_r,
                       out_removed_r, out_status_r};

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pos_nxt         = pos_r;
    mv_nxt          = mv_r;
    cv_nxt          = cv_r;
    left_big_nxt    = left_big_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_top_nxt     = out_top_r;
    out_count_nxt   = out_count_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_m1[ADDR_W-1:0];
    ram_wdata       = mv_r;
    ram_raddr       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          status_nxt  = ST_OK;
          removed_nxt = '0;
          if (in_tuser[0] == REQ_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FINISH;
            end else begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              pos_nxt   = cnt_r + CNT_W'(1);
              mv_nxt    = $signed(in_tdata[VAL_W-1:0]);
              state_nxt = S_UP_STEP;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FINISH;
            end else begin
              removed_nxt = root_r;
              cnt_nxt     = cnt_m1;
              if (cnt_r == CNT_W'(1)) begin
                state_nxt = S_FINISH;
              end else begin
                ram_raddr = cnt_m1[ADDR_W-1:0];
                state_nxt = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP_STEP: begin
        if (pos_r == CNT_W'(1)) begin
          ram_we    = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          ram_raddr = parent_m1[ADDR_W-1:0];
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (rd_val < mv_r) begin
          ram_wdata = rd_val;
          pos_nxt   = parent;
          state_nxt = S_UP_STEP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DN_LAST: begin
        mv_nxt  = rd_val;
        pos_nxt = CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = rd_val;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DN_STEP;
        end
      end
      S_DN_STEP: begin
        if (left > cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          ram_raddr = left_m1[ADDR_W-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        left_big_nxt = left_wins;
        cv_nxt       = left_wins ? rd_val : mv_r;
        if (right <= cnt_ext) begin
          ram_raddr = left[ADDR_W-1:0];
          state_nxt = S_DN_R;
        end else begin
          ram_we = 1'b1;
          if (left_wins) begin
            ram_wdata = rd_val;
            pos_nxt   = left[CNT_W-1:0];
            state_nxt = S_DN_STEP;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_DN_R: begin
        ram_we = 1'b1;
        if (rd_val > cv_r) begin
          ram_wdata = rd_val;
          pos_nxt   = right[CNT_W-1:0];
          state_nxt = S_DN_STEP;
        end else if (left_big_r) begin
          ram_wdata = cv_r;
          pos_nxt   = left[CNT_W-1:0];
          state_nxt = S_DN_STEP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = removed_r;
          out_top_nxt     = (cnt_r == '0) ? '0 : root_r;
          out_count_nxt   = cnt_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    root_nxt = (ram_we && ram_waddr == '0) ? $signed(ram_wdata) : root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r         <= pos_nxt;
    mv_r          <= mv_nxt;
    cv_r          <= cv_nxt;
    left_big_r    <= left_big_nxt;
    root_r        <= root_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_top_r     <= out_top_nxt;
    out_count_r   <= out_count_nxt;
  end

  `MHPQ_ASSERT(a_cnt_range, cnt_r <= CNT_W'(CAPACITY), "fill count beyond capacity")
  `MHPQ_ASSERT(a_wr_in_heap, ram_we |-> (CNT_W'(ram_waddr) < cnt_r), "write outside heap")
  `MHPQ_ASSERT(a_full_count, (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_W'(CAPACITY)), "full status with room left")
  `MHPQ_ASSERT(a_empty_result, (out_valid_r && out_status_r == ST_EMPTY) |-> (out_count_r == '0 && out_removed_r == '0), "empty status with entries")

endmodule

/* tb/tb_max_heap_priority_queue.sv */
// Testbench for max_heap_priority_queue: directed and random insert/remove traffic
// with random stalls on both streams, checked by a scoreboard holding its own heap.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.
`timescale 1ns / 100ps

module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_FROM   = 1600;
  localparam int DRAIN_CYCLES = 50;
  localparam int ST_LSB       = 0;
  localparam int RM_LSB       = ST_LSB + STATUS_W;
  localparam int TOP_LSB      = RM_LSB + VAL_W;
  localparam int CNT_LSB      = TOP_LSB + VAL_W;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  removed_value;
    logic signed [VAL_W-1:0]  top_value;
    logic [CNT_W-1:0]         entry_count;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [VAL_W-1:0] slots [1:CAPACITY];
    int                      fill;
    heap_result_t            pending_results [$];
    int                      errors;
    int                      inserts;
    int                      removes;
    int                      empty_hits;
    int                      full_hits;
    int                      checked;

    function new();
      fill = 0;
      errors = 0;
      inserts = 0;
      removes = 0;
      empty_hits = 0;
      full_hits = 0;
      checked = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic signed [VAL_W-1:0] t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void note_request(logic req, logic signed [VAL_W-1:0] val);
      heap_result_t res;
      int           pos;
      int           lft;
      int           rgt;
      int           big;
      res.status = ST_OK;
      res.removed_value = '0;
      if (req == REQ_INSERT) begin
        inserts++;
        if (fill >= CAPACITY) begin
          res.status = ST_FULL;
          full_hits++;
        end else begin
          fill++;
          slots[fill] = val;
          pos = fill;
          while (pos > 1 && slots[pos / 2] < slots[pos]) begin
            swap_slots(pos / 2, pos);
            pos = pos / 2;
          end
        end
      end else begin
        removes++;
        if (fill == 0) begin
          res.status = ST_EMPTY;
          empty_hits++;
        end else begin
          res.removed_value = slots[1];
          slots[1] = slots[fill];
          fill--;
          pos = 1;
          while (fill > 1) begin
            lft = 2 * pos;
            rgt = lft + 1;
            big = pos;
            if (lft <= fill && slots[big] < slots[lft]) big = lft;
            if (rgt <= fill && slots[big] < slots[rgt]) big = rgt;
            if (big == pos) break;
            swap_slots(pos, big);
            pos = big;
          end
        end
      end
      res.top_value = (fill != 0) ? slots[1] : '0;
      res.entry_count = fill[CNT_W-1:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      heap_result_t            exp;
      status_t                 got_status;
      logic signed [VAL_W-1:0] got_removed;
      logic signed [VAL_W-1:0] got_top;
      logic [CNT_W-1:0]        got_count;
      got_status  = status_t'(d[ST_LSB +: STATUS_W]);
      got_removed = d[RM_LSB +: VAL_W];
      got_top     = d[TOP_LSB +: VAL_W];
      got_count   = d[CNT_LSB +: CNT_W];
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: status %0d count %0d",
               got_status, got_count);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if (got_status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got_status);
        errors++;
      end
      if (got_removed !== exp.removed_value) begin
        $error("removed_value: expected %0d, got %0d", exp.removed_value, got_removed);
        errors++;
      end
      if (got_top !== exp.top_value) begin
        $error("top_value: expected %0d, got %0d", exp.top_value, got_top);
        errors++;
      end
      if (got_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got_count);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // value
  logic [0:0]             in_tuser;   // req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, removed_value, top_value, entry_count

  heap_scoreboard sb;
  bit             quiet;
  int             sent;
  int             stall_left;

  max_heap_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("max_heap_priority_queue verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_request(in_tuser[0], in_tdata[VAL_W-1:0]);
    end
  end

  // receiver: random stall bursts, none in the quiet tail
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 3) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_req(logic req, logic [VAL_W-1:0] val);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = val;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0000_0000;
           default: return 32'hFFFF_FFFF;
         endcase
      1, 2, 3: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    send_req(REQ_REMOVE, $urandom);
    send_req(REQ_INSERT, 32'h0000_0000);
    send_req(REQ_INSERT, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 32'h8000_0000);
    send_req(REQ_INSERT, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 32'd5);
    send_req(REQ_INSERT, 32'd5);
    send_req(REQ_INSERT, 32'd5);
    send_req(REQ_INSERT, 32'd1);
    repeat (4) send_req(REQ_REMOVE, $urandom);
    send_req(REQ_INSERT, -32'sd5);
    send_req(REQ_INSERT, -32'sd5);
    send_req(REQ_INSERT, 32'd7);
    send_req(REQ_INSERT, 32'hAAAA_5555);
    repeat (9) send_req(REQ_REMOVE, $urandom);
  endtask

  task automatic run_random();
    int  phase_len;
    int  insert_pct;
    bit  paused;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        if (sent >= RANDOM_ITEMS) break;
        quiet = (sent >= QUIET_FROM);
        if (!paused && sent >= RANDOM_ITEMS / 2) begin
          paused = 1'b1;
          @(negedge clk);
          in_tvalid = 1'b0;
          while (sb.outstanding() != 0) @(negedge clk);
        end
        if ($urandom_range(0, 99) < insert_pct) send_req(REQ_INSERT, pick_value());
        else send_req(REQ_REMOVE, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random();

    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d inserts (%0d on full), %0d removes (%0d on empty)",
             sb.checked, sb.inserts, sb.full_hits, sb.removes, sb.empty_hits);
    if (sb.errors == 0) begin
      $display("max_heap_priority_queue verification clean");
    end else begin
      $display("max_heap_priority_queue verification failed");
    end
    $finish;
  end

endmodule
